/* rtl/core/nnc_pkg.sv */
package nnc_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int SCAN_MAX    = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 256;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W       = (CNT_W > 9) ? CNT_W : 9;

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    localparam int REG_TRAIN_COUNT = 0;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  label;
    } entry_t;

    typedef struct packed {
        logic       vld;
        logic       first;
        logic [7:0] idx;
    } tag_t;

endpackage

/* rtl/core/nearest_neighbour_classifier_2d_top.sv */
// A load beat is accepted and gives no result; loads may follow back to back.
// A classify beat rotates the ring of TABLE_DEPTH table cells once past a
// three-stage distance unit. The result is presented once the scan is done and the
// distance unit has drained, and later while an earlier result waits.
// The next beat can be accepted in the same cycle in which the result is presented.
// Reset clears the control state and sets train_count to 1; the table stays undefined.
module nearest_neighbour_classifier_2d_top
    import nnc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [0:0]         opcode,
    input  logic [7:0]         entry_index,
    input  logic signed [15:0] coord_x,
    input  logic signed [15:0] coord_y,
    input  logic [7:0]         class_label,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         predicted_label,
    output logic [7:0]         nearest_index,
    output logic [32:0]        min_distance
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [8:0]         train_count_reg;
    logic signed [15:0] qx_reg;
    logic signed [15:0] qy_reg;

    logic               out_valid_reg;
    logic [7:0]         out_label_reg;
    logic [7:0]         out_idx_reg;
    logic [32:0]        out_dist_reg;

    logic               in_fire;
    logic               cfg_we;
    logic               scanning;
    logic               last_step;
    logic               finish;
    logic [CMP_W-1:0]   n_eff;
    logic               active;
    entry_t             load_data;
    entry_t             cells [TABLE_DEPTH];
    tag_t               tag;
    logic               busy;
    logic [7:0]         best_label;
    logic [7:0]         best_idx;
    logic [32:0]        best_dist;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'(REG_TRAIN_COUNT));
    assign prdata = (paddr[2] == 1'(REG_TRAIN_COUNT)) ? {23'd0, train_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            train_count_reg <= 9'd1;
        end
        else if (cfg_we)
        begin
            train_count_reg <= pwdata[8:0];
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign scanning  = (state_reg == ST_SCAN);
    assign last_step = (cnt_reg == CNT_W'(TABLE_DEPTH - 1));
    assign finish    = (state_reg == ST_DRAIN) && !busy && (!out_valid_reg || out_ready);

    always_comb
    begin
        if (train_count_reg == 9'd0)
        begin
            n_eff = CMP_W'(1);
        end
        else if (CMP_W'(train_count_reg) > CMP_W'(SCAN_MAX))
        begin
            n_eff = CMP_W'(SCAN_MAX);
        end
        else
        begin
            n_eff = CMP_W'(train_count_reg);
        end
    end

    assign active = CMP_W'(cnt_reg) < n_eff;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_fire && (opcode == OP_CLASSIFY))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (opcode == OP_CLASSIFY))
        begin
            qx_reg <= coord_x;
            qy_reg <= coord_y;
        end
        if (finish)
        begin
            out_label_reg <= best_label;
            out_idx_reg   <= best_idx;
            out_dist_reg  <= best_dist;
        end
    end

    assign load_data.x     = coord_x;
    assign load_data.y     = coord_y;
    assign load_data.label = class_label;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic load_en;

        assign load_en = in_fire && (opcode == OP_LOAD) && (int'(entry_index) == i);

        nnc_cell u_cell (
            .clk       (clk),
            .load_en   (load_en),
            .load_data (load_data),
            .shift_en  (scanning),
            .shift_in  (cells[(i + 1) % TABLE_DEPTH]),
            .data      (cells[i])
        );
    end

    assign tag.vld   = scanning && active;
    assign tag.first = (cnt_reg == '0);
    assign tag.idx   = 8'(cnt_reg);

    nnc_dist u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .tag        (tag),
        .entry      (cells[0]),
        .qx         (qx_reg),
        .qy         (qy_reg),
        .busy       (busy),
        .best_label (best_label),
        .best_idx   (best_idx),
        .best_dist  (best_dist)
    );

    assign out_valid       = out_valid_reg;
    assign predicted_label = out_label_reg;
    assign nearest_index   = out_idx_reg;
    assign min_distance    = out_dist_reg;

    a_ready_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !busy)
        else $error("input taken while the distance pipeline still holds a step");

    a_result_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DRAIN))
        else $error("result raised without a completed scan");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (CMP_W'(nearest_index) < n_eff))
        else $error("nearest index lies beyond the searched entries");

endmodule

/* rtl/core/nnc_cell.sv */
module nnc_cell
    import nnc_pkg::*;
(
    input  logic   clk,
    input  logic   load_en,
    input  entry_t load_data,
    input  logic   shift_en,
    input  entry_t shift_in,
    output entry_t data
);

    entry_t data_reg;

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            data_reg <= load_data;
        end
        else if (shift_en)
        begin
            data_reg <= shift_in;
        end
    end

    assign data = data_reg;

endmodule

/* rtl/core/nnc_dist.sv */
module nnc_dist
    import nnc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  tag_t               tag,
    input  entry_t             entry,
    input  logic signed [15:0] qx,
    input  logic signed [15:0] qy,
    output logic               busy,
    output logic [7:0]         best_label,
    output logic [7:0]         best_idx,
    output logic [32:0]        best_dist
);

    logic               s1_vld_reg;
    logic               s1_first_reg;
    logic [7:0]         s1_idx_reg;
    logic [7:0]         s1_label_reg;
    logic signed [16:0] s1_dx_reg;
    logic signed [16:0] s1_dy_reg;

    logic               s2_vld_reg;
    logic               s2_first_reg;
    logic [7:0]         s2_idx_reg;
    logic [7:0]         s2_label_reg;
    logic [31:0]        s2_sqx_reg;
    logic [31:0]        s2_sqy_reg;

    logic [32:0]        best_dist_reg;
    logic [7:0]         best_idx_reg;
    logic [7:0]         best_label_reg;

    logic signed [16:0] dx_next;
    logic signed [16:0] dy_next;
    logic signed [33:0] sqx_full;
    logic signed [33:0] sqy_full;
    logic [32:0]        sum_next;
    logic               take_next;

    assign dx_next  = $signed({qx[15], qx}) - $signed({entry.x[15], entry.x});
    assign dy_next  = $signed({qy[15], qy}) - $signed({entry.y[15], entry.y});
    assign sqx_full = s1_dx_reg * s1_dx_reg;
    assign sqy_full = s1_dy_reg * s1_dy_reg;
    assign sum_next = {1'b0, s2_sqx_reg} + {1'b0, s2_sqy_reg};
    assign take_next = s2_vld_reg && (s2_first_reg || (sum_next < best_dist_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= tag.vld;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= tag.first;
        s1_idx_reg   <= tag.idx;
        s1_label_reg <= entry.label;
        s1_dx_reg    <= dx_next;
        s1_dy_reg    <= dy_next;

        s2_first_reg <= s1_first_reg;
        s2_idx_reg   <= s1_idx_reg;
        s2_label_reg <= s1_label_reg;
        s2_sqx_reg   <= sqx_full[31:0];
        s2_sqy_reg   <= sqy_full[31:0];

        if (take_next)
        begin
            best_dist_reg  <= sum_next;
            best_idx_reg   <= s2_idx_reg;
            best_label_reg <= s2_label_reg;
        end
    end

    assign busy       = s1_vld_reg || s2_vld_reg;
    assign best_label = best_label_reg;
    assign best_idx   = best_idx_reg;
    assign best_dist  = best_dist_reg;

endmodule

/* test/tb.sv */
module tb;
    import nnc_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 7;
    localparam int SETTLE_CYCLES   = TABLE_DEPTH + 16;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int MAX_PRINTED     = 100;

    localparam logic [2:0] TRAIN_COUNT_ADDR = 3'(4 * REG_TRAIN_COUNT);
    localparam logic [2:0] SPARE_ADDR       = 3'(4 * (REG_TRAIN_COUNT + 1));

    localparam logic signed [15:0] COORD_MIN = 16'sh8000;
    localparam logic signed [15:0] COORD_MAX = 16'sh7FFF;

    typedef struct packed {
        logic [7:0]  label;
        logic [7:0]  index;
        logic [32:0] distance;
    } nearest_match_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic [0:0]         opcode;
    logic [7:0]         entry_index;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic [7:0]         class_label;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         predicted_label;
    logic [7:0]         nearest_index;
    logic [32:0]        min_distance;

    logic signed [15:0] x_store [TABLE_DEPTH];
    logic signed [15:0] y_store [TABLE_DEPTH];
    logic [7:0]         label_store [TABLE_DEPTH];
    logic [8:0]         train_count_copy = 9'd1;
    nearest_match_t     pending_matches [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;
    int segment_no     = 0;

    nearest_neighbour_classifier_2d_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .entry_index     (entry_index),
        .coord_x         (coord_x),
        .coord_y         (coord_y),
        .class_label     (class_label),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .predicted_label (predicted_label),
        .nearest_index   (nearest_index),
        .min_distance    (min_distance)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // The receiver either holds off for a counted stretch or stalls at random.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready = 1'b0;
            hold_cycles--;
        end
        else
        begin
            out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic int searched_entries();
        int n;
        n = train_count_copy;
        if (n == 0)
        begin
            n = 1;
        end
        if (n > SCAN_MAX)
        begin
            n = SCAN_MAX;
        end
        return n;
    endfunction

    function automatic nearest_match_t find_nearest(input logic signed [15:0] qx,
                                                    input logic signed [15:0] qy);
        nearest_match_t best;
        longint         dx;
        longint         dy;
        longint         sq_dist;
        longint         best_dist;
        int             n;
        n         = searched_entries();
        best      = '0;
        best_dist = 0;
        for (int j = 0; j < n; j++)
        begin
            dx      = longint'(qx) - longint'(x_store[j]);
            dy      = longint'(qy) - longint'(y_store[j]);
            sq_dist = dx * dx + dy * dy;
            if (j == 0 || sq_dist < best_dist)
            begin
                best_dist  = sq_dist;
                best.label = label_store[j];
                best.index = 8'(j);
            end
        end
        best.distance = 33'(best_dist);
        return best;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
        begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
    endtask

    always @(posedge clk)
    begin : check_and_predict
        nearest_match_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_matches.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result: label %0d index %0d dist %0d",
                                              predicted_label, nearest_index, min_distance));
                end
                else
                begin
                    want = pending_matches.pop_front();
                    if (predicted_label !== want.label)
                    begin
                        report_mismatch($sformatf("predicted_label %0d, wanted %0d",
                                                  predicted_label, want.label));
                    end
                    if (nearest_index !== want.index)
                    begin
                        report_mismatch($sformatf("nearest_index %0d, wanted %0d",
                                                  nearest_index, want.index));
                    end
                    if (min_distance !== want.distance)
                    begin
                        report_mismatch($sformatf("min_distance %0d, wanted %0d",
                                                  min_distance, want.distance));
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (opcode == OP_LOAD)
                begin
                    x_store[entry_index]     = coord_x;
                    y_store[entry_index]     = coord_y;
                    label_store[entry_index] = class_label;
                end
                else
                begin
                    pending_matches.push_back(find_nearest(coord_x, coord_y));
                end
            end
        end
    end

    task automatic drain(input int settle);
        while (pending_matches.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [8:0] value);
        drain(SETTLE_CYCLES);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = {23'd0, value};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (addr == TRAIN_COUNT_ADDR)
        begin
            train_count_copy = value;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_item(input logic [0:0] op, input logic [7:0] slot,
                             input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic [7:0] lab);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
        end
        in_valid    = 1'b1;
        opcode      = op;
        entry_index = slot;
        coord_x     = x;
        coord_y     = y;
        class_label = lab;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(7))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [8:0] next_count_setting();
        segment_no++;
        case (segment_no % 5)
            0: return 9'd256;
            1: return 9'd1;
            2: return 9'd511;
            3: return 9'd0;
            default: return 9'($urandom_range(255, 2));
        endcase
    endfunction

    // A load may copy the point of an already written slot so that ties occur.
    task automatic send_random_load(input int slot, input int filled);
        logic signed [15:0] x;
        logic signed [15:0] y;
        int                 src;
        x = pick_coord();
        y = pick_coord();
        if (filled > 0 && $urandom_range(3) == 0)
        begin
            src = $urandom_range(filled - 1);
            x   = x_store[src];
            y   = y_store[src];
        end
        send_item(OP_LOAD, 8'(slot), x, y, 8'($urandom));
    endtask

    task automatic send_random_query();
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        int                 j;
        j = $urandom_range(searched_entries() - 1);
        case ($urandom_range(9))
            5, 6, 7:
            begin
                qx = 16'(int'(x_store[j]) + int'($urandom_range(16)) - 8);
                qy = 16'(int'(y_store[j]) + int'($urandom_range(16)) - 8);
            end
            8:
            begin
                qx = x_store[j];
                qy = y_store[j];
            end
            default:
            begin
                qx = pick_coord();
                qy = pick_coord();
            end
        endcase
        send_item(OP_CLASSIFY, 8'($urandom), qx, qy, 8'($urandom));
    endtask

    task automatic test_directed();
        send_item(OP_LOAD, 8'd0, COORD_MIN, COORD_MIN, 8'hA5);
        send_item(OP_CLASSIFY, 8'hFF, COORD_MAX, COORD_MAX, 8'hFF);
        send_item(OP_CLASSIFY, 8'h00, COORD_MIN, COORD_MIN, 8'h00);
        write_register(TRAIN_COUNT_ADDR, 9'd0);
        send_item(OP_CLASSIFY, 8'h5C, 16'sd0, 16'sd0, 8'h3C);
        write_register(TRAIN_COUNT_ADDR, 9'd4);
        send_item(OP_LOAD, 8'd1, COORD_MAX, COORD_MAX, 8'hFF);
        send_item(OP_LOAD, 8'd2, 16'sd1, 16'sd0, 8'h5A);
        send_item(OP_LOAD, 8'd3, -16'sd1, 16'sd0, 8'h00);
        send_item(OP_LOAD, 8'd255, COORD_MAX, COORD_MIN, 8'h81);
        // Slots 2 and 3 lie at the same distance from the origin; the lower one must win.
        send_item(OP_CLASSIFY, 8'd3, 16'sd0, 16'sd0, 8'h77);
        send_item(OP_CLASSIFY, 8'd0, COORD_MAX, COORD_MAX, 8'd0);
        send_item(OP_CLASSIFY, 8'd1, COORD_MIN, COORD_MAX, 8'd0);
        write_register(SPARE_ADDR, 9'd1);
        send_item(OP_CLASSIFY, 8'd0, -16'sd1, 16'sd0, 8'd0);
        write_register(TRAIN_COUNT_ADDR, 9'd3);
        send_item(OP_CLASSIFY, 8'd0, -16'sd1, 16'sd0, 8'd0);
    endtask

    task automatic test_table_fill();
        for (int slot = 0; slot < TABLE_DEPTH; slot++)
        begin
            send_random_load(slot, slot);
        end
    endtask

    task automatic test_random_traffic(input int n_items, input int send_pct,
                                       input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int s = 0; s < 4; s++)
        begin
            write_register(TRAIN_COUNT_ADDR, next_count_setting());
            for (int k = 0; k < n_items / 4; k++)
            begin
                if ($urandom_range(99) < 55)
                begin
                    send_random_query();
                end
                else
                begin
                    send_random_load($urandom_range(TABLE_DEPTH - 1), TABLE_DEPTH);
                end
            end
        end
    endtask

    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_register(TRAIN_COUNT_ADDR, 9'd256);
        @(posedge clk);
        hold_cycles = HOLD_OFF_CYCLES;
        @(negedge clk);
        for (int k = 0; k < 24; k++)
        begin
            if (k % 3 == 0)
            begin
                send_random_load($urandom_range(TABLE_DEPTH - 1), TABLE_DEPTH);
            end
            else
            begin
                send_random_query();
            end
        end
        drain(0);
        for (int k = 0; k < 24; k++)
        begin
            if (k % 3 == 0)
            begin
                send_random_load($urandom_range(TABLE_DEPTH - 1), TABLE_DEPTH);
            end
            else
            begin
                send_random_query();
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        opcode      = OP_LOAD;
        entry_index = '0;
        coord_x     = '0;
        coord_y     = '0;
        class_label = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_table_fill();
        test_random_traffic(400, 0, 0);
        test_random_traffic(400, 46, 0);
        test_random_traffic(400, 0, 46);
        test_random_traffic(400, 19, 19);
        test_output_backpressure();

        drain(SETTLE_CYCLES);
        if (mismatch_count == 0 && pending_matches.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
